[hdl/dfclt_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the data frame client learning table.
// Depends on nothing; data_frame_client_learning_table imports it.

package dfclt_pkg;

    // Number of learned entries the table can hold.
    localparam int TABLE_DEPTH = 10;

    // Entry index and entry count widths follow from the depth.
    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    localparam int ADDR_W  = 48;
    localparam int ENTRY_W = 2 * ADDR_W;

    // Frame qualification constants.
    localparam logic [7:0]  FC_TYPE_MASK = 8'h0C;
    localparam logic [7:0]  FC_TYPE_DATA = 8'h08;
    localparam logic [15:0] MIN_LEN_EXCL = 16'd36;

    typedef struct packed {
        logic [7:0]        frame_control;
        logic [15:0]       frame_length;
        logic [ADDR_W-1:0] source_addr;
        logic [ADDR_W-1:0] bssid_addr;
    } in_word_t;

    typedef struct packed {
        logic       qualified;
        logic       already_known;
        logic       newly_added;
        logic       dropped_full;
        logic [3:0] slot_index;
        logic [3:0] stored_count;
    } out_word_t;

endpackage

[hdl/dfclt_ram.sv]
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.

module dfclt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                     aclk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[hdl/data_frame_client_learning_table.sv]
`timescale 1ns / 1ps
// Top level of the data frame client learning table: handshake, scan sequencer
// and result register. Depends on dfclt_pkg and dfclt_ram.
//
//   Port group   Dir  Handshake          Word type
//   s_*          in   s_valid / s_ready  in_word_t  (frame summary)
//   m_*          out  m_valid / m_ready  out_word_t (learning result)
//
// A qualifying frame scans the learned entries in order, each entry by a RAM
// read in ST_READ, then a compare in ST_CMP using the single 48-bit comparator.
// A hit ends the scan; when every held entry misses, ST_DECIDE adds the frame
// if the table has room and flags it as dropped otherwise. A frame that does
// not qualify goes from ST_CHECK straight to ST_OUT. s_ready is high only
// while idle; a result waits in its register until m_ready takes it.
// Reset clears the state and the entry count; table contents are never cleared, since
// entries at or above the count are never read.

module data_frame_client_learning_table
    import dfclt_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_word_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_word_t m_data
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_READ,
        ST_CMP,
        ST_DECIDE,
        ST_OUT
    } state_t;

    state_t     state_reg, state_next;
    in_word_t   item_reg, item_next;
    out_word_t  res_reg, res_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] count_reg, count_next;

    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic [ENTRY_W-1:0] ram_rdata;
    logic               qual;
    logic               hit;
    logic               last_entry;

    // Each entry holds the BSSID in the upper half and the source address below.
    dfclt_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(TABLE_DEPTH)
    ) u_entry_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    assign qual = ((item_reg.frame_control & FC_TYPE_MASK) == FC_TYPE_DATA)
                  && (item_reg.frame_length > MIN_LEN_EXCL);
    assign hit        = (ram_rdata[ADDR_W-1:0] == item_reg.source_addr);
    assign last_entry = ((CNT_W'(idx_reg) + CNT_W'(1)) == count_reg);

    assign ram_waddr = count_reg[IDX_W-1:0];
    assign ram_wdata = {item_reg.bssid_addr, item_reg.source_addr};

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = (state_reg == ST_OUT);
    assign m_data  = res_reg;

    always_comb begin
        state_next = state_reg;
        item_next  = item_reg;
        res_next   = res_reg;
        idx_next   = idx_reg;
        count_next = count_reg;
        ram_we     = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    item_next  = s_data;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                res_next = '0;
                res_next.stored_count = 4'(count_reg);
                idx_next = '0;
                if (!qual) begin
                    state_next = ST_OUT;
                end else begin
                    res_next.qualified = 1'b1;
                    if (count_reg == '0) begin
                        state_next = ST_DECIDE;
                    end else begin
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ: begin
                state_next = ST_CMP;
            end
            ST_CMP: begin
                if (hit) begin
                    res_next.already_known = 1'b1;
                    res_next.slot_index    = 4'(idx_reg);
                    state_next             = ST_OUT;
                end else if (last_entry) begin
                    state_next = ST_DECIDE;
                end else begin
                    idx_next   = idx_reg + IDX_W'(1);
                    state_next = ST_READ;
                end
            end
            ST_DECIDE: begin
                if (count_reg < CNT_W'(TABLE_DEPTH)) begin
                    ram_we                = 1'b1;
                    count_next            = count_reg + CNT_W'(1);
                    res_next.newly_added  = 1'b1;
                    res_next.slot_index   = 4'(count_reg);
                    res_next.stored_count = 4'(count_reg + CNT_W'(1));
                end else begin
                    res_next.dropped_full = 1'b1;
                end
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
        item_reg <= item_next;
        res_reg  <= res_next;
        idx_reg  <= idx_next;
    end

endmodule
